[hdl/aff_pkg.sv]
// shared constants, types and helper functions for the affine matrix builder
`default_nettype none
package aff_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_ITERS = 30;
   // fold stage, one stage per iteration, round and clamp stage
   localparam int SINCOS_LAT   = CORDIC_ITERS + 2;
   localparam int CW   = 34;              // cordic datapath width
   localparam int SC_W = FRAC_BITS + 2;   // sine and cosine, range -1.0 .. 1.0
   localparam int PW   = 2 * SC_W;        // product of two trig values
   localparam int RW   = FRAC_BITS + 3;   // rotation entry, range -2.0 .. 2.0
   localparam int XW   = RW + 32;         // rotation entry times a Q16.16 word

   // opcodes
   localparam logic OP_MODEL  = 1'b0;
   localparam logic OP_CAMERA = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } side_type;

   typedef struct packed {
      logic signed [SC_W-1:0] sin_x;
      logic signed [SC_W-1:0] cos_x;
      logic signed [SC_W-1:0] sin_y;
      logic signed [SC_W-1:0] cos_y;
      logic signed [SC_W-1:0] sin_z;
      logic signed [SC_W-1:0] cos_z;
   } trig_type;

   // elem[col][row] for rows 0 to 2
   typedef struct packed {
      logic [3:0][2:0][31:0] elem;
   } matrix_type;

   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
         3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
         9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
         15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
         21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
         24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   // round half up by FRAC_BITS, then clamp to signed 32 bits
   function automatic logic [31:0] round_sat(input logic signed [63:0] v);
      logic signed [63:0] w;
      w = v + (64'sd1 <<< (FRAC_BITS - 1));
      w = w >>> FRAC_BITS;
      if (w > 64'sd2147483647) begin
         return 32'h7FFFFFFF;
      end else if (w < -64'sd2147483648) begin
         return 32'h80000000;
      end
      return w[31:0];
   endfunction

endpackage
`default_nettype wire

[hdl/aff_sincos.sv]
// pipelined cordic lane: binary angle to rounded sine and cosine
`default_nettype none
module aff_sincos
   import aff_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire logic [15:0]            angle,
   output logic signed [SC_W-1:0]      sin_val,
   output logic signed [SC_W-1:0]      cos_val
);

   localparam logic [31:0] ANGLE_MASK = (32'd1 << ANGLE_BITS) - 32'd1;
   localparam logic signed [CW-1:0] GAIN_START = CW'(652032874);
   localparam int RSH = 30 - FRAC_BITS;
   localparam logic signed [CW-1:0] RND_HALF = CW'(1) << (RSH - 1);
   localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
   localparam logic signed [CW-1:0] MONE = -ONE;

   logic signed [CW-1:0] x_ff [0:CORDIC_ITERS];
   logic signed [CW-1:0] y_ff [0:CORDIC_ITERS];
   logic signed [CW-1:0] z_ff [0:CORDIC_ITERS];
   logic                 flip_ff [0:CORDIC_ITERS];

   logic [31:0] phase_raw, phase_chk, phase_fold;
   logic        flip_in;

   always_comb begin
      phase_raw  = (32'(angle) & ANGLE_MASK) << (32 - ANGLE_BITS);
      phase_chk  = phase_raw + 32'h40000000;
      flip_in    = phase_chk[31];
      phase_fold = flip_in ? (phase_raw + 32'h80000000) : phase_raw;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= GAIN_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= {{(CW-32){phase_fold[31]}}, phase_fold};
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      localparam logic signed [CW-1:0] ATAN = CW'(atan_entry(i));
      logic signed [CW-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (enable) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
         end
      end
   end

   logic signed [CW-1:0] xr, yr, xc, yc;
   logic signed [SC_W-1:0] sin_ff, cos_ff, sin_in, cos_in;

   always_comb begin
      xr = (x_ff[CORDIC_ITERS] + RND_HALF) >>> RSH;
      yr = (y_ff[CORDIC_ITERS] + RND_HALF) >>> RSH;
      xc = (xr > ONE) ? ONE : ((xr < MONE) ? MONE : xr);
      yc = (yr > ONE) ? ONE : ((yr < MONE) ? MONE : yr);
      if (flip_ff[CORDIC_ITERS]) begin
         xc = -xc;
         yc = -yc;
      end
      cos_in = SC_W'(xc);
      sin_in = SC_W'(yc);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule
`default_nettype wire

[hdl/aff_matrix.sv]
// five stage pipeline: rotation entries, then scaled and translated columns
`default_nettype none
module aff_matrix
   import aff_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       enable,
   input  wire logic       in_valid,
   input  wire trig_type   trig_in,
   input  wire side_type   side_in,
   output logic            out_valid,
   output matrix_type      mat_out
);

   localparam logic signed [PW-1:0]  HALF_P  = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [PW:0]    HALF_S  = (PW+1)'(1) << (FRAC_BITS - 1);

   function automatic logic signed [SC_W-1:0] mul_rnd(input logic signed [SC_W-1:0] a,
                                                     input logic signed [SC_W-1:0] b);
      logic signed [PW-1:0] pr;
      pr = a * b;
      pr = (pr + HALF_P) >>> FRAC_BITS;
      return SC_W'(pr);
   endfunction

   function automatic logic signed [RW-1:0] sum_rnd(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b);
      logic signed [PW:0] s;
      s = (PW+1)'(a) + (PW+1)'(b);
      s = (s + HALF_S) >>> FRAC_BITS;
      return RW'(s);
   endfunction

   // stage a: single products
   logic                   valid_a_ff;
   side_type               side_a_ff;
   trig_type               trig_a_ff;
   logic signed [SC_W-1:0] p_a_ff, q_a_ff, r00_a_ff, r01_a_ff, r12_a_ff, r22_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_a_ff <= side_in;
         trig_a_ff <= trig_in;
         p_a_ff    <= mul_rnd(trig_in.sin_y, trig_in.cos_z);
         q_a_ff    <= mul_rnd(trig_in.sin_y, trig_in.sin_z);
         r00_a_ff  <= mul_rnd(trig_in.cos_y, trig_in.cos_z);
         r01_a_ff  <= -mul_rnd(trig_in.cos_y, trig_in.sin_z);
         r12_a_ff  <= -mul_rnd(trig_in.sin_x, trig_in.cos_y);
         r22_a_ff  <= mul_rnd(trig_in.cos_x, trig_in.cos_y);
      end
   end

   // stage b: cross products for rows 1 and 2
   logic                   valid_b_ff;
   side_type               side_b_ff;
   logic signed [SC_W-1:0] r00_b_ff, r01_b_ff, r02_b_ff, r12_b_ff, r22_b_ff;
   logic signed [PW-1:0]   m_b_ff [0:7];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_b_ff <= side_a_ff;
         r00_b_ff  <= r00_a_ff;
         r01_b_ff  <= r01_a_ff;
         r02_b_ff  <= trig_a_ff.sin_y;
         r12_b_ff  <= r12_a_ff;
         r22_b_ff  <= r22_a_ff;
         m_b_ff[0] <= trig_a_ff.cos_x * trig_a_ff.sin_z;
         m_b_ff[1] <= trig_a_ff.sin_x * p_a_ff;
         m_b_ff[2] <= trig_a_ff.cos_x * trig_a_ff.cos_z;
         m_b_ff[3] <= trig_a_ff.sin_x * q_a_ff;
         m_b_ff[4] <= trig_a_ff.sin_x * trig_a_ff.sin_z;
         m_b_ff[5] <= trig_a_ff.cos_x * p_a_ff;
         m_b_ff[6] <= trig_a_ff.sin_x * trig_a_ff.cos_z;
         m_b_ff[7] <= trig_a_ff.cos_x * q_a_ff;
      end
   end

   // stage c: full rotation matrix
   logic                 valid_c_ff;
   side_type             side_c_ff;
   logic signed [RW-1:0] r_c_ff [0:2][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else if (enable) begin
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_c_ff    <= side_b_ff;
         r_c_ff[0][0] <= RW'(r00_b_ff);
         r_c_ff[0][1] <= RW'(r01_b_ff);
         r_c_ff[0][2] <= RW'(r02_b_ff);
         r_c_ff[1][0] <= sum_rnd(m_b_ff[0], m_b_ff[1]);
         r_c_ff[1][1] <= sum_rnd(m_b_ff[2], -m_b_ff[3]);
         r_c_ff[1][2] <= RW'(r12_b_ff);
         r_c_ff[2][0] <= sum_rnd(m_b_ff[4], -m_b_ff[5]);
         r_c_ff[2][1] <= sum_rnd(m_b_ff[6], m_b_ff[7]);
         r_c_ff[2][2] <= RW'(r22_b_ff);
      end
   end

   // stage d: products with scale and translation
   logic signed [31:0] sc_c [0:2];
   logic signed [31:0] tr_c [0:2];

   always_comb begin
      sc_c[0] = side_c_ff.scale_x;
      sc_c[1] = side_c_ff.scale_y;
      sc_c[2] = side_c_ff.scale_z;
      tr_c[0] = side_c_ff.trans_x;
      tr_c[1] = side_c_ff.trans_y;
      tr_c[2] = side_c_ff.trans_z;
   end

   logic                 valid_d_ff;
   side_type             side_d_ff;
   logic signed [XW-1:0] ps_d_ff [0:2][0:2];
   logic signed [XW-1:0] pt_d_ff [0:2][0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else if (enable) begin
         valid_d_ff <= valid_c_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         always_ff @(posedge clock) begin
            if (enable) begin
               ps_d_ff[r][c] <= r_c_ff[r][c] * sc_c[c];
               pt_d_ff[r][c] <= r_c_ff[r][c] * tr_c[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_d_ff <= side_c_ff;
      end
   end

   // stage e: round and saturate, summing the translation products for the camera opcode
   logic        valid_e_ff;
   matrix_type  mat_e_ff, mat_e_in;
   logic signed [31:0] tr_d [0:2];

   always_comb begin
      tr_d[0] = side_d_ff.trans_x;
      tr_d[1] = side_d_ff.trans_y;
      tr_d[2] = side_d_ff.trans_z;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mat_e_in.elem[c][r] = round_sat(64'(ps_d_ff[r][c]));
         end
         if (side_d_ff.opcode == OP_CAMERA) begin
            mat_e_in.elem[3][r] = round_sat(64'(pt_d_ff[r][0]) + 64'(pt_d_ff[r][1])
                                            + 64'(pt_d_ff[r][2]));
         end else begin
            mat_e_in.elem[3][r] = tr_d[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_e_ff <= 1'b0;
      end else if (enable) begin
         valid_e_ff <= valid_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mat_e_ff <= mat_e_in;
      end
   end

   assign out_valid = valid_e_ff;
   assign mat_out   = mat_e_ff;

endmodule
`default_nettype wire

[hdl/aff_colout.sv]
// column serializer: holds one matrix and sends it as four column words
`default_nettype none
module aff_colout
   import aff_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire matrix_type  mat_in,
   output logic             pipe_enable,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_column_index,
   output logic [31:0]      rsp_row0_value,
   output logic [31:0]      rsp_row1_value,
   output logic [31:0]      rsp_row2_value,
   output logic [31:0]      rsp_row3_value,
   output logic             rsp_last_column
);

   localparam logic [1:0]  LAST_COL = 2'd3;
   localparam logic [31:0] ONE_FIX  = 32'd1 << FRAC_BITS;

   logic        hold_valid_ff, hold_valid_in;
   logic [1:0]  col_ff, col_in;
   matrix_type  mat_ff;
   logic        can_take, load, sent;

   always_comb begin
      sent          = hold_valid_ff && rsp_ready;
      can_take      = !hold_valid_ff || (sent && (col_ff == LAST_COL));
      pipe_enable   = can_take || !in_valid;
      load          = can_take && in_valid;
      hold_valid_in = hold_valid_ff;
      col_in        = col_ff;
      if (load) begin
         hold_valid_in = 1'b1;
         col_in        = 2'd0;
      end else if (sent) begin
         if (col_ff == LAST_COL) begin
            hold_valid_in = 1'b0;
         end else begin
            col_in = col_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         col_ff        <= 2'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         col_ff        <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mat_ff <= mat_in;
      end
   end

   assign rsp_valid        = hold_valid_ff;
   assign rsp_column_index = col_ff;
   assign rsp_row0_value   = mat_ff.elem[col_ff][0];
   assign rsp_row1_value   = mat_ff.elem[col_ff][1];
   assign rsp_row2_value   = mat_ff.elem[col_ff][2];
   assign rsp_row3_value   = (col_ff == LAST_COL) ? ONE_FIX : 32'd0;
   assign rsp_last_column  = (col_ff == LAST_COL);

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && col_ff != LAST_COL)
      |=> (rsp_valid && col_ff == $past(col_ff) + 2'd1))
      else $error("column did not advance after a word was taken");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(col_ff) && $stable(mat_ff)))
      else $error("held matrix changed during a stall");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!hold_valid_ff || (rsp_ready && col_ff == LAST_COL)))
      else $error("new matrix loaded over an unfinished one");

endmodule
`default_nettype wire

[hdl/affine_transform_matrix_builder_top.sv]
// top level of the translate, rotate, scale 4x4 matrix builder
//
// input channel req_*: one word holds opcode, translation, three binary angles
// and scale; it is taken when req_valid and req_ready are both high
// opcode 0 builds the model matrix T*Rx*Ry*Rz*S, opcode 1 the camera matrix
// Rx*Ry*Rz*T*S whose translation column is the rotated translation
// result channel rsp_*: four words per input, column 0 first, rsp_last_column
// marks column 3; elements are signed Q16.16, saturated to 32 bits
// a word passes through the cordic lanes (three side by side, one iteration
// per stage), then five matrix stages and the column register before column 0
// shows up on the result channel
// throughput: the result channel moves one column per cycle while rsp_ready
// is high, four columns per input word; the pipeline takes a new word every
// cycle while the column register has room
// when the receiver stalls nothing is dropped or repeated; the pipeline holds
// and req_ready falls while a finished matrix waits for the column register
// reset (synchronous, active high) clears all valid bits and the column count
`default_nettype none
module affine_transform_matrix_builder_top
   import aff_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_trans_x,
   input  wire logic [31:0] req_trans_y,
   input  wire logic [31:0] req_trans_z,
   input  wire logic [15:0] req_angle_x,
   input  wire logic [15:0] req_angle_y,
   input  wire logic [15:0] req_angle_z,
   input  wire logic [31:0] req_scale_x,
   input  wire logic [31:0] req_scale_y,
   input  wire logic [31:0] req_scale_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_column_index,
   output logic [31:0]      rsp_row0_value,
   output logic [31:0]      rsp_row1_value,
   output logic [31:0]      rsp_row2_value,
   output logic [31:0]      rsp_row3_value,
   output logic             rsp_last_column
);

   logic       pipe_enable;
   side_type   side_in;
   trig_type   trig;

   // valid bits and pass-along fields ride next to the cordic lanes
   logic       valid_ff [0:SINCOS_LAT-1];
   side_type   side_ff  [0:SINCOS_LAT-1];

   assign req_ready = pipe_enable;

   always_comb begin
      side_in.opcode  = req_opcode;
      side_in.trans_x = req_trans_x;
      side_in.trans_y = req_trans_y;
      side_in.trans_z = req_trans_z;
      side_in.scale_x = req_scale_x;
      side_in.scale_y = req_scale_y;
      side_in.scale_z = req_scale_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SINCOS_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (pipe_enable) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < SINCOS_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < SINCOS_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // one cordic lane per axis
   aff_sincos u_sincos_x (
      .clock   (clock),
      .enable  (pipe_enable),
      .angle   (req_angle_x),
      .sin_val (trig.sin_x),
      .cos_val (trig.cos_x)
   );

   aff_sincos u_sincos_y (
      .clock   (clock),
      .enable  (pipe_enable),
      .angle   (req_angle_y),
      .sin_val (trig.sin_y),
      .cos_val (trig.cos_y)
   );

   aff_sincos u_sincos_z (
      .clock   (clock),
      .enable  (pipe_enable),
      .angle   (req_angle_z),
      .sin_val (trig.sin_z),
      .cos_val (trig.cos_z)
   );

   logic       mat_valid;
   matrix_type mat;

   // rotation, scale and translation
   aff_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (valid_ff[SINCOS_LAT-1]),
      .trig_in   (trig),
      .side_in   (side_ff[SINCOS_LAT-1]),
      .out_valid (mat_valid),
      .mat_out   (mat)
   );

   // column register and output mux
   aff_colout u_colout (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (mat_valid),
      .mat_in           (mat),
      .pipe_enable      (pipe_enable),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column_index (rsp_column_index),
      .rsp_row0_value   (rsp_row0_value),
      .rsp_row1_value   (rsp_row1_value),
      .rsp_row2_value   (rsp_row2_value),
      .rsp_row3_value   (rsp_row3_value),
      .rsp_last_column  (rsp_last_column)
   );

endmodule
`default_nettype wire
